// ===== rtl/lfpcd_pkg.sv =====
`default_nettype none

package lfpcd_pkg;

    localparam int unsigned FRAME_LENGTH = 9;
    localparam int unsigned REG_COUNT = 5;
    localparam int unsigned ADDR_WIDTH = 5;

    localparam logic [7:0] HEADER_BYTE = 8'h59;
    localparam logic [7:0] HEADER_SUM = 8'(2 * HEADER_BYTE);
    localparam logic [15:0] AMP_OVERLOAD = 16'hFFFF;
    localparam logic [31:0] UPTIME_LOW = 32'd2000;
    localparam logic [31:0] UPTIME_HIGH = 32'd5000;
    localparam logic [3:0] CHECKSUM_INDEX = 4'(FRAME_LENGTH - 1);
    localparam logic [3:0] FIRST_BODY_INDEX = 4'd2;

    typedef enum logic [2:0] {
        REG_NORMAL_DISTANCE = 3'd0,
        REG_JUMP_THRESHOLD = 3'd1,
        REG_SAMPLE_INTERVAL = 3'd2,
        REG_MIN_DISTANCE = 3'd3,
        REG_MAX_DISTANCE = 3'd4
    } t_reg_index;

    typedef enum logic [2:0] {
        PH_HUNT_FIRST = 3'b001,
        PH_HUNT_SECOND = 3'b010,
        PH_BODY = 3'b100
    } t_phase;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic [31:0] now_ms;
        logic [31:0] up_time_ms;
        logic bump_active;
        logic power_starting;
    } t_in_word;

    typedef struct packed {
        logic frame_done;
        logic checksum_error;
        logic overexposed;
        logic [15:0] distance;
        logic [15:0] amplitude;
        logic [15:0] temperature_raw;
        logic cliff_suspect;
        logic cliff_flag;
    } t_out_word;

    typedef struct packed {
        logic [15:0] normal_distance;
        logic [15:0] jump_threshold;
        logic [15:0] sample_interval_ms;
        logic [15:0] min_distance;
        logic [15:0] max_distance;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/lfpcd_regs.sv =====
`default_nettype none

module lfpcd_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lfpcd_pkg::ADDR_WIDTH-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output lfpcd_pkg::t_cfg                      o_cfg
);
    import lfpcd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    t_reg_index addr_index;
    logic wr_en;

    assign addr_index = t_reg_index'(paddr[ADDR_WIDTH-1:2]);
    assign wr_en = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (addr_index)
                REG_NORMAL_DISTANCE: n_cfg.normal_distance = pwdata[15:0];
                REG_JUMP_THRESHOLD: n_cfg.jump_threshold = pwdata[15:0];
                REG_SAMPLE_INTERVAL: n_cfg.sample_interval_ms = pwdata[15:0];
                REG_MIN_DISTANCE: n_cfg.min_distance = pwdata[15:0];
                REG_MAX_DISTANCE: n_cfg.max_distance = pwdata[15:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (addr_index)
            REG_NORMAL_DISTANCE: prdata = {16'd0, r_cfg.normal_distance};
            REG_JUMP_THRESHOLD: prdata = {16'd0, r_cfg.jump_threshold};
            REG_SAMPLE_INTERVAL: prdata = {16'd0, r_cfg.sample_interval_ms};
            REG_MIN_DISTANCE: prdata = {16'd0, r_cfg.min_distance};
            REG_MAX_DISTANCE: prdata = {16'd0, r_cfg.max_distance};
            default: prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/lfpcd_core.sv =====
`default_nettype none

module lfpcd_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_step,
    input  wire lfpcd_pkg::t_in_word  i_word,
    input  wire lfpcd_pkg::t_cfg      i_cfg,
    output lfpcd_pkg::t_out_word      o_result
);
    import lfpcd_pkg::*;

    t_phase r_phase, n_phase;
    logic [3:0] r_byte_count, n_byte_count;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_frame [8];
    logic [15:0] r_prev_distance, n_prev_distance;
    logic r_prev_valid, n_prev_valid;
    logic [31:0] r_next_judge, n_next_judge;
    logic [15:0] r_distance, n_distance;
    logic [15:0] r_amplitude, n_amplitude;
    logic [15:0] r_temperature, n_temperature;
    logic r_cliff, n_cliff;

    logic frame_wr;
    logic [15:0] f_distance, f_amplitude, f_temperature;
    logic done, cserr, over, suspect, good;
    logic judge, prev_valid_judge, clear_hit, set_hit;
    logic [15:0] jump;

    assign f_distance = {r_frame[3], r_frame[2]};
    assign f_amplitude = {r_frame[5], r_frame[4]};
    assign f_temperature = {r_frame[7], r_frame[6]};
    assign jump = f_distance - r_prev_distance;

    always_comb begin
        n_phase = r_phase;
        n_byte_count = r_byte_count;
        n_sum = r_sum;
        frame_wr = 1'b0;
        done = 1'b0;
        cserr = 1'b0;
        over = 1'b0;
        good = 1'b0;
        unique case (r_phase)
            PH_HUNT_FIRST: begin
                if (i_word.rx_byte == HEADER_BYTE) begin
                    n_phase = PH_HUNT_SECOND;
                    n_byte_count = 4'd1;
                end else begin
                    n_byte_count = 4'd0;
                end
            end
            PH_HUNT_SECOND: begin
                if (i_word.rx_byte == HEADER_BYTE) begin
                    n_phase = PH_BODY;
                    n_byte_count = FIRST_BODY_INDEX;
                    n_sum = HEADER_SUM;
                end else begin
                    n_phase = PH_HUNT_FIRST;
                    n_byte_count = 4'd0;
                end
            end
            PH_BODY: begin
                if (r_byte_count >= CHECKSUM_INDEX) begin
                    done = 1'b1;
                    if (r_sum != i_word.rx_byte) begin
                        cserr = 1'b1;
                    end else if (f_amplitude == AMP_OVERLOAD) begin
                        over = 1'b1;
                    end else begin
                        good = 1'b1;
                    end
                    n_phase = PH_HUNT_FIRST;
                    n_byte_count = 4'd0;
                end else begin
                    frame_wr = 1'b1;
                    n_sum = r_sum + i_word.rx_byte;
                    n_byte_count = r_byte_count + 4'd1;
                end
            end
            default: begin
                n_phase = PH_HUNT_FIRST;
                n_byte_count = 4'd0;
            end
        endcase
    end

    assign judge = good && (i_word.now_ms >= r_next_judge);
    assign clear_hit = good && (f_distance < i_cfg.min_distance)
        && (i_word.up_time_ms > UPTIME_LOW);
    assign set_hit = good && (f_distance > i_cfg.max_distance)
        && (i_word.up_time_ms > UPTIME_LOW) && (i_word.up_time_ms < UPTIME_HIGH);

    always_comb begin
        prev_valid_judge = r_prev_valid && !i_word.power_starting;
        if (i_word.bump_active) begin
            prev_valid_judge = 1'b0;
        end
        suspect = judge && (f_distance > i_cfg.normal_distance)
            && (r_prev_distance > i_cfg.normal_distance)
            && (f_distance > r_prev_distance)
            && (jump >= i_cfg.jump_threshold) && prev_valid_judge;

        n_prev_valid = r_prev_valid && !i_word.power_starting;
        n_prev_distance = r_prev_distance;
        n_next_judge = r_next_judge;
        n_distance = r_distance;
        n_amplitude = r_amplitude;
        n_temperature = r_temperature;
        n_cliff = r_cliff;
        if (good) begin
            n_distance = f_distance;
            n_amplitude = f_amplitude;
            n_temperature = f_temperature;
        end
        if (judge) begin
            n_prev_distance = f_distance;
            n_prev_valid = 1'b1;
            n_next_judge = i_word.now_ms + {16'd0, i_cfg.sample_interval_ms};
        end
        if (clear_hit) begin
            n_cliff = 1'b0;
            n_prev_valid = 1'b0;
        end
        if (set_hit) begin
            n_cliff = 1'b1;
            n_prev_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT_FIRST;
            r_byte_count <= 4'd0;
            r_sum <= 8'd0;
            r_prev_distance <= 16'd0;
            r_prev_valid <= 1'b0;
            r_next_judge <= 32'd0;
            r_distance <= 16'd0;
            r_amplitude <= 16'd0;
            r_temperature <= 16'd0;
            r_cliff <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_byte_count <= n_byte_count;
            r_sum <= n_sum;
            r_prev_distance <= n_prev_distance;
            r_prev_valid <= n_prev_valid;
            r_next_judge <= n_next_judge;
            r_distance <= n_distance;
            r_amplitude <= n_amplitude;
            r_temperature <= n_temperature;
            r_cliff <= n_cliff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && frame_wr) begin
            r_frame[r_byte_count[2:0]] <= i_word.rx_byte;
        end
    end

    always_comb begin
        o_result.frame_done = done;
        o_result.checksum_error = cserr;
        o_result.overexposed = over;
        o_result.distance = n_distance;
        o_result.amplitude = n_amplitude;
        o_result.temperature_raw = n_temperature;
        o_result.cliff_suspect = suspect;
        o_result.cliff_flag = n_cliff;
    end

endmodule

`default_nettype wire

// ===== rtl/lidar_frame_parse_cliff_detect.sv =====
`default_nettype none
// Channel   Direction  Ports                                  Word
// input     in         i_in_valid, o_in_stall, i_in_word      one serial byte plus time/status
// output    out        o_out_valid, i_out_stall, o_out_word   frame status and last reading
// config    in         psel, penable, pwrite, paddr, pwdata   five 16-bit registers
//
// Each word passes through the input register and then the result register, so a result
// word is offered once its input word has moved into the result register, and one word is
// taken every cycle while the result word is not stalled.
// The frame state advances as a word moves from the input register to the result register.
// Reset is synchronous and active low; the frame buffer itself is not reset.
// A stalled result holds the result register and a full input register, and o_in_stall is
// high while both are full and the result word is stalled.

module lidar_frame_parse_cliff_detect (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire lfpcd_pkg::t_in_word              i_in_word,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output lfpcd_pkg::t_out_word                  o_out_word,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [lfpcd_pkg::ADDR_WIDTH-1:0] paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import lfpcd_pkg::*;

    t_cfg cfg;
    t_in_word r_in_word;
    logic r_in_valid;
    t_out_word r_out_word;
    logic r_out_valid;
    t_out_word result;
    logic out_load, move, accept;

    assign pready = 1'b1;
    assign out_load = !r_out_valid || !i_out_stall;
    assign move = r_in_valid && out_load;
    assign o_in_stall = r_in_valid && !out_load;
    assign accept = i_in_valid && !o_in_stall;

    lfpcd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    lfpcd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (move),
        .i_word   (r_in_word),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_word <= i_in_word;
        end
        if (move) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word = r_out_word;

endmodule

`default_nettype wire
